@@ rtl/keyframe_curve_evaluator_assert.svh @@
// Assertion macros used by the keyframe curve evaluator checker
`ifndef KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH
`define KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset
`define KCE_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyframe curve evaluator check failed");

// Next-cycle implication, sampled on clock, off during reset
`define KCE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyframe curve evaluator check failed");

`endif

@@ rtl/kce_pkg.sv @@
// Package: types, codes and constants of the keyframe curve evaluator
`default_nettype none
package kce_pkg;

   localparam int TIME_W       = 16;
   localparam int VALUE_W      = 32;
   localparam int FRAC_W       = 17;
   localparam int FRAC_BITS    = 16;
   localparam int MAX_KEYS_DEF = 16;

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

   localparam logic [1:0] CMD_EVAL     = 2'd0;
   localparam logic [1:0] CMD_ADD      = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam logic [1:0] MODE_CONST        = 2'd0;
   localparam logic [1:0] MODE_TWO_CONST    = 2'd1;
   localparam logic [1:0] MODE_MIN_CURVE    = 2'd2;
   localparam logic [1:0] MODE_BLEND_CURVES = 2'd3;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_CONST_MIN = 2'd1;
   localparam logic [1:0] CSR_CONST_MAX = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [1:0]                command;
      logic                      curve_sel;
      logic signed [TIME_W-1:0]  time_req;
      logic signed [VALUE_W-1:0] value;
      logic [FRAC_W-1:0]         rand_frac;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result;
      logic                      status;
   } rsp_word_type;

   typedef struct packed {
      logic signed [TIME_W-1:0]  key_time;
      logic signed [VALUE_W-1:0] key_value;
   } key_type;

   function automatic logic [FRAC_W-1:0] sat_frac(input logic [FRAC_W-1:0] f);
      sat_frac = (f > FRAC_ONE) ? FRAC_ONE : f;
   endfunction

endpackage
`default_nettype wire

@@ rtl/kce_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module kce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/kce_div.sv @@
// Restoring divider, one fraction bit per cycle; expects num < den
`default_nettype none
module kce_div import kce_pkg::*; #(
   parameter int NUM_W = TIME_W + 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [NUM_W-1:0]     num,
   input  wire logic [NUM_W-1:0]     den,
   output logic                      done,
   output logic      [FRAC_BITS-1:0] quot
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     den_ff, den_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [NUM_W:0]       shl;
   logic [NUM_W:0]       sub;
   logic                 ge;

   always_comb begin
      shl     = {rem_ff, 1'b0};
      sub     = shl - {1'b0, den_ff};
      ge      = shl >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRAC_BITS);
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? sub[NUM_W-1:0] : shl[NUM_W-1:0];
         quot_in = {quot_ff[FRAC_BITS-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

@@ rtl/keyframe_curve_evaluator.sv @@
// Top level: keyframe curve evaluator sequencer around the key RAM
`default_nettype none
// Keyframe curve evaluator. Two sorted key tables (min curve, max curve) share
// one key RAM, curve select as the top address bit, one read and one write
// port, registered read data. A command word is taken when start is high
// and busy is low; exactly one result word follows, shown for one cycle with
// rsp_strobe, and the receiver cannot stall it. Steps, set by the RAM's one
// read per cycle and the bit-serial divider:
//   mode 0 evaluate, clear, unused command, add to a full table: answered from idle.
//   mode 1 evaluate: two-stage blend: multiply, then add.
//   add: each later key is read, compared and moved up one slot to make
//   room, then the new key is written into its slot (slot 0 or above).
//   curve evaluate: an empty table ends straight away, one-key or out-of-range
//   times after the first or last key read; inside the range a binary search,
//   then the divider, then the blend.
//   mode 3 runs the min then the max curve, then one more blend.
// Key reads and writes never overlap: each insert step reads, compares and
// only then writes, so no forwarding is needed. Key tables come up undefined;
// entries past a table's count are never read. Config writes are always
// accepted and must only be issued while busy is low.
module keyframe_curve_evaluator import kce_pkg::*; #(
   parameter int MAX_KEYS = MAX_KEYS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_word_type       req_word,
   output logic                    rsp_strobe,
   output rsp_word_type            rsp_word,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [VALUE_W-1:0] csr_data
);

   localparam int AW      = $clog2(MAX_KEYS);
   localparam int CW      = $clog2(MAX_KEYS + 1);
   localparam int RAM_AW  = AW + 1;
   localparam int RAM_D   = 2 ** RAM_AW;
   localparam int KEY_W   = TIME_W + VALUE_W;
   localparam int DIFF_W  = TIME_W + 1;
   localparam int PROD_W  = VALUE_W + FRAC_W + 2;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_EV_START   = 4'd1;
   localparam logic [3:0] S_EV_FIRST   = 4'd2;
   localparam logic [3:0] S_EV_LAST    = 4'd3;
   localparam logic [3:0] S_EV_SEARCH  = 4'd4;
   localparam logic [3:0] S_EV_MID     = 4'd5;
   localparam logic [3:0] S_EV_DIV     = 4'd6;
   localparam logic [3:0] S_BLEND      = 4'd7;
   localparam logic [3:0] S_BLEND_SUM  = 4'd8;
   localparam logic [3:0] S_CURVE_DONE = 4'd9;
   localparam logic [3:0] S_ADD_RD     = 4'd10;
   localparam logic [3:0] S_ADD_CK     = 4'd11;

   // control state
   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_min_ff, cnt_min_in;
   logic [CW-1:0]       cnt_max_ff, cnt_max_in;
   logic [1:0]          csr_mode_ff, csr_mode_in;
   logic [VALUE_W-1:0]  csr_cmin_ff, csr_cmin_in;
   logic [VALUE_W-1:0]  csr_cmax_ff, csr_cmax_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // working registers
   req_word_type        req_ff, req_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;
   logic                curve_ff, curve_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   key_type             lo_key_ff, lo_key_in;
   key_type             hi_key_ff, hi_key_in;
   logic [VALUE_W-1:0]  curve_val_ff, curve_val_in;
   logic [VALUE_W-1:0]  cmin_val_ff, cmin_val_in;
   logic [VALUE_W-1:0]  bl_a_ff, bl_a_in;
   logic [VALUE_W-1:0]  bl_b_ff, bl_b_in;
   logic [FRAC_W-1:0]   bl_f_ff, bl_f_in;
   logic                bl_fin_ff, bl_fin_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // RAM and divider hookup
   logic                ram_wr_en;
   logic [RAM_AW-1:0]   ram_wr_addr;
   logic [KEY_W-1:0]    ram_wr_data;
   logic [RAM_AW-1:0]   ram_rd_addr;
   logic [KEY_W-1:0]    ram_rd_data;
   key_type             rd_key;
   key_type             new_key;
   logic                div_start;
   logic                div_done;
   logic [FRAC_BITS-1:0] div_quot;

   // helpers
   logic [CW-1:0]             cur_cnt;
   logic [CW-1:0]             sel_cnt;
   logic [CW-1:0]             last_idx;
   logic [CW-1:0]             mid;
   logic [CW-1:0]             idx_dec;
   logic signed [DIFF_W-1:0]  span;
   logic signed [DIFF_W-1:0]  tdiff;
   logic signed [VALUE_W:0]   bl_diff;
   logic signed [PROD_W-1:0]  bl_sum;
   logic signed [TIME_W-1:0]  t_eval;

   kce_ram #(
      .WIDTH (KEY_W),
      .DEPTH (RAM_D)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   kce_div #(
      .NUM_W (DIFF_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (tdiff),
      .den   (span),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rd_key  = key_type'(ram_rd_data);
   assign t_eval  = req_ff.time_req;
   assign cur_cnt = curve_ff ? cnt_max_ff : cnt_min_ff;
   assign sel_cnt = req_word.curve_sel ? cnt_max_ff : cnt_min_ff;
   assign last_idx = cur_cnt - CW'(1);
   assign idx_dec  = idx_ff - CW'(1);
   assign mid      = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign span  = {hi_key_ff.key_time[TIME_W-1], hi_key_ff.key_time}
                - {lo_key_ff.key_time[TIME_W-1], lo_key_ff.key_time};
   assign tdiff = {t_eval[TIME_W-1], t_eval}
                - {lo_key_ff.key_time[TIME_W-1], lo_key_ff.key_time};
   // a + floor((b - a) * f / 2^16): arithmetic shift floors the product
   assign bl_diff = {bl_b_ff[VALUE_W-1], bl_b_ff} - {bl_a_ff[VALUE_W-1], bl_a_ff};
   assign bl_sum  = PROD_W'($signed(bl_a_ff)) + (prod_ff >>> FRAC_BITS);

   always_comb begin
      new_key.key_time  = req_ff.time_req;
      new_key.key_value = req_ff.value;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_min_in    = cnt_min_ff;
      cnt_max_in    = cnt_max_ff;
      csr_mode_in   = csr_mode_ff;
      csr_cmin_in   = csr_cmin_ff;
      csr_cmax_in   = csr_cmax_ff;
      rsp_strobe_in = 1'b0;
      req_in        = req_ff;
      rsp_word_in   = rsp_word_ff;
      curve_in      = curve_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      lo_key_in     = lo_key_ff;
      hi_key_in     = hi_key_ff;
      curve_val_in  = curve_val_ff;
      cmin_val_in   = cmin_val_ff;
      bl_a_in       = bl_a_ff;
      bl_b_in       = bl_b_ff;
      bl_f_in       = bl_f_ff;
      bl_fin_in     = bl_fin_ff;
      prod_in       = prod_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {curve_ff, idx_ff[AW-1:0]};
      ram_wr_data   = KEY_W'(new_key);
      ram_rd_addr   = {curve_ff, AW'(0)};
      div_start     = 1'b0;

      // register writes, idle only: a rule for the user, the block does not enforce it
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:      csr_mode_in = csr_data[1:0];
            CSR_CONST_MIN: csr_cmin_in = csr_data;
            CSR_CONST_MAX: csr_cmax_in = csr_data;
            default:       ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               curve_in = req_word.curve_sel;
               rsp_word_in.result = '0;
               rsp_word_in.status = STATUS_OK;
               unique case (req_word.command)
                  CMD_EVAL: begin
                     unique case (csr_mode_ff)
                        MODE_CONST: begin
                           rsp_word_in.result = csr_cmin_ff;
                           rsp_strobe_in      = 1'b1;
                        end
                        MODE_TWO_CONST: begin
                           bl_a_in   = csr_cmin_ff;
                           bl_b_in   = csr_cmax_ff;
                           bl_f_in   = sat_frac(req_word.rand_frac);
                           bl_fin_in = 1'b1;
                           state_in  = S_BLEND;
                        end
                        default: begin
                           curve_in = 1'b0;
                           state_in = S_EV_START;
                        end
                     endcase
                  end
                  CMD_ADD: begin
                     if (sel_cnt == CW'(MAX_KEYS)) begin
                        rsp_word_in.status = STATUS_FULL;
                        rsp_strobe_in      = 1'b1;
                     end else begin
                        idx_in   = sel_cnt;
                        state_in = S_ADD_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     if (req_word.curve_sel) begin
                        cnt_max_in = '0;
                     end else begin
                        cnt_min_in = '0;
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_EV_START: begin
            if (cur_cnt == '0) begin
               curve_val_in = '0;
               state_in     = S_CURVE_DONE;
            end else begin
               ram_rd_addr = {curve_ff, AW'(0)};
               state_in    = S_EV_FIRST;
            end
         end
         S_EV_FIRST: begin
            lo_key_in = rd_key;
            if (cur_cnt == CW'(1) || t_eval <= rd_key.key_time) begin
               curve_val_in = rd_key.key_value;
               state_in     = S_CURVE_DONE;
            end else begin
               ram_rd_addr = {curve_ff, last_idx[AW-1:0]};
               state_in    = S_EV_LAST;
            end
         end
         S_EV_LAST: begin
            hi_key_in = rd_key;
            if (t_eval >= rd_key.key_time) begin
               curve_val_in = rd_key.key_value;
               state_in     = S_CURVE_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = last_idx;
               state_in = S_EV_SEARCH;
            end
         end
         S_EV_SEARCH: begin
            if (hi_ff - lo_ff > CW'(1)) begin
               ram_rd_addr = {curve_ff, mid[AW-1:0]};
               state_in    = S_EV_MID;
            end else if (span <= 0) begin
               curve_val_in = lo_key_ff.key_value;
               state_in     = S_CURVE_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_EV_DIV;
            end
         end
         S_EV_MID: begin
            if (rd_key.key_time <= t_eval) begin
               lo_in     = mid;
               lo_key_in = rd_key;
            end else begin
               hi_in     = mid;
               hi_key_in = rd_key;
            end
            state_in = S_EV_SEARCH;
         end
         S_EV_DIV: begin
            if (div_done) begin
               bl_a_in   = lo_key_ff.key_value;
               bl_b_in   = hi_key_ff.key_value;
               bl_f_in   = {1'b0, div_quot};
               bl_fin_in = 1'b0;
               state_in  = S_BLEND;
            end
         end
         S_BLEND: begin
            prod_in  = PROD_W'(bl_diff) * PROD_W'($signed({1'b0, bl_f_ff}));
            state_in = S_BLEND_SUM;
         end
         S_BLEND_SUM: begin
            if (bl_fin_ff) begin
               rsp_word_in.result = bl_sum[VALUE_W-1:0];
               rsp_strobe_in      = 1'b1;
               state_in           = S_IDLE;
            end else begin
               curve_val_in = bl_sum[VALUE_W-1:0];
               state_in     = S_CURVE_DONE;
            end
         end
         S_CURVE_DONE: begin
            if (csr_mode_ff == MODE_BLEND_CURVES) begin
               if (!curve_ff) begin
                  cmin_val_in = curve_val_ff;
                  curve_in    = 1'b1;
                  state_in    = S_EV_START;
               end else begin
                  bl_a_in   = cmin_val_ff;
                  bl_b_in   = curve_val_ff;
                  bl_f_in   = sat_frac(req_ff.rand_frac);
                  bl_fin_in = 1'b1;
                  state_in  = S_BLEND;
               end
            end else begin
               rsp_word_in.result = curve_val_ff;
               rsp_strobe_in      = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_ADD_RD: begin
            if (idx_ff == '0) begin
               ram_wr_en     = 1'b1;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (curve_ff) begin
                  cnt_max_in = cnt_max_ff + CW'(1);
               end else begin
                  cnt_min_in = cnt_min_ff + CW'(1);
               end
            end else begin
               ram_rd_addr = {curve_ff, idx_dec[AW-1:0]};
               state_in    = S_ADD_CK;
            end
         end
         S_ADD_CK: begin
            ram_wr_en = 1'b1;
            // later key moves up one slot; equal times stay ahead of the new key
            if (rd_key.key_time > req_ff.time_req) begin
               ram_wr_data = ram_rd_data;
               idx_in      = idx_dec;
               state_in    = S_ADD_RD;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (curve_ff) begin
                  cnt_max_in = cnt_max_ff + CW'(1);
               end else begin
                  cnt_min_in = cnt_min_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_min_ff    <= '0;
         cnt_max_ff    <= '0;
         csr_mode_ff   <= MODE_CONST;
         csr_cmin_ff   <= '0;
         csr_cmax_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_min_ff    <= cnt_min_in;
         cnt_max_ff    <= cnt_max_in;
         csr_mode_ff   <= csr_mode_in;
         csr_cmin_ff   <= csr_cmin_in;
         csr_cmax_ff   <= csr_cmax_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_word_ff  <= rsp_word_in;
      curve_ff     <= curve_in;
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      lo_key_ff    <= lo_key_in;
      hi_key_ff    <= hi_key_in;
      curve_val_ff <= curve_val_in;
      cmin_val_ff  <= cmin_val_in;
      bl_a_ff      <= bl_a_in;
      bl_b_ff      <= bl_b_in;
      bl_f_ff      <= bl_f_in;
      bl_fin_ff    <= bl_fin_in;
      prod_ff      <= prod_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
`default_nettype wire

@@ rtl/kce_checker.sv @@
// Port-level checker for the keyframe curve evaluator, bound to the top level
`default_nettype none
`include "keyframe_curve_evaluator_assert.svh"
module kce_checker import kce_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire logic         rsp_strobe,
   input wire rsp_word_type rsp_word
);

   // an accepted word either answers next cycle or keeps the block busy
   `KCE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_strobe)
   // a result always closes out the command
   `KCE_ASSERT_IMPLY(a_strobe_idle, rsp_strobe, !busy)
   // busy only drops with a result
   `KCE_ASSERT_IMPLY(a_fell_strobe, $fell(busy), rsp_strobe)
   // a dropped key reports zero
   `KCE_ASSERT_IMPLY(a_full_zero, rsp_strobe && rsp_word.status, rsp_word.result == '0)

endmodule

bind keyframe_curve_evaluator kce_checker u_kce_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
`default_nettype wire
